// ===== sv/pidm_pkg.sv =====
// Package for the position PID motor drive: field widths, register
// indexes, item kinds and the control-register bundle type.
// No dependencies.
`default_nettype none

package pidm_pkg;

    // Default sizes handed to the top-level parameters
    localparam int COUNT_BITS_DEF     = 24;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int DUTY_BITS_DEF      = 8;

    // Fixed register widths
    localparam int GAIN_W     = 16;
    localparam int BAND_W     = 16;
    localparam int LIMIT_W    = 23;
    localparam int SUM_W      = LIMIT_W + 1;   // error sum stays within +-limit
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Reset value of the duty ceiling before masking to the duty width
    localparam int DUTY_CEIL_RESET = 255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_DT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_DT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEIL  = 3'd6;

    // Input item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // Loop tuning registers of fixed width
    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i_dt;
        logic [GAIN_W-1:0]  gain_d_over_dt;
        logic [BAND_W-1:0]  dead_band;
        logic [LIMIT_W-1:0] sum_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/pidm_core.sv =====
// PID arithmetic for one control tick: error, deadband test, clamped sum,
// Q-format PID output, duty clamp/floor and bridge direction.
// Depends on pidm_pkg.
`default_nettype none

module pidm_core
    import pidm_pkg::*;
#(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int DUTY_BITS      = DUTY_BITS_DEF
) (
    input  var t_cfg                           i_cfg,
    input  wire logic        [DUTY_BITS-1:0]   i_duty_floor,
    input  wire logic        [DUTY_BITS-1:0]   i_duty_ceiling,
    input  wire logic signed [COUNT_BITS-1:0]  i_target,
    input  wire logic signed [SUM_W-1:0]       i_error_sum,
    input  wire logic signed [COUNT_BITS:0]    i_last_error,
    input  wire logic signed [COUNT_BITS-1:0]  i_value,
    output logic signed      [SUM_W-1:0]       o_error_sum_next,
    output logic signed      [COUNT_BITS:0]    o_last_error_next,
    output logic             [DUTY_BITS-1:0]   o_fwd_duty,
    output logic             [DUTY_BITS-1:0]   o_rev_duty,
    output logic                               o_settled
);

    localparam int ERR_W  = COUNT_BITS + 1;
    localparam int DIFF_W = COUNT_BITS + 2;
    localparam int ACC_W  = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;
    localparam int MAG_W  = (ERR_W > BAND_W) ? ERR_W : BAND_W;
    localparam int PRD_W  = GAIN_W + 1 + DIFF_W;
    localparam int PID_W  = PRD_W + 2;
    localparam logic signed [PID_W-1:0] TRUNC_BIAS =
        PID_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    logic signed [ERR_W-1:0]  err;
    logic        [ERR_W-1:0]  err_mag;
    logic                     in_band;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  lim;
    logic signed [ACC_W-1:0]  acc_clamp;
    logic signed [SUM_W-1:0]  sum_new;
    logic signed [DIFF_W-1:0] diff;
    logic signed [GAIN_W:0]   gp, gi, gd;
    logic signed [PRD_W-1:0]  prod_p, prod_i, prod_d;
    logic signed [PID_W-1:0]  pid_raw, pid_biased, pid_q, ceil_s, pid_clamp, pid_neg;
    logic        [DUTY_BITS-1:0] duty_mag, duty_out;

    // Error and deadband test
    assign err     = ERR_W'(i_target) - ERR_W'(i_value);
    assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign in_band = MAG_W'(err_mag) < MAG_W'(i_cfg.dead_band);

    // Error sum, clamped to +-limit
    assign acc = ACC_W'(i_error_sum) + ACC_W'(err);
    assign lim = $signed(ACC_W'(i_cfg.sum_limit));
    always_comb begin
        if (acc > lim) begin
            acc_clamp = lim;
        end else if (acc < -lim) begin
            acc_clamp = -lim;
        end else begin
            acc_clamp = acc;
        end
    end
    assign sum_new = SUM_W'(acc_clamp);

    // Three gain products, summed exactly
    assign diff   = DIFF_W'(err) - DIFF_W'(i_last_error);
    assign gp     = $signed({1'b0, i_cfg.gain_p});
    assign gi     = $signed({1'b0, i_cfg.gain_i_dt});
    assign gd     = $signed({1'b0, i_cfg.gain_d_over_dt});
    assign prod_p = PRD_W'(gp) * PRD_W'(err);
    assign prod_i = PRD_W'(gi) * PRD_W'(sum_new);
    assign prod_d = PRD_W'(gd) * PRD_W'(diff);
    assign pid_raw = PID_W'(prod_p) + PID_W'(prod_i) + PID_W'(prod_d);

    // Drop fraction bits, rounding toward zero
    assign pid_biased = pid_raw + (pid_raw[PID_W-1] ? TRUNC_BIAS : PID_W'(0));
    assign pid_q      = pid_biased >>> GAIN_FRAC_BITS;

    // Clamp to +-ceiling
    assign ceil_s = $signed(PID_W'(i_duty_ceiling));
    always_comb begin
        if (pid_q > ceil_s) begin
            pid_clamp = ceil_s;
        end else if (pid_q < -ceil_s) begin
            pid_clamp = -ceil_s;
        end else begin
            pid_clamp = pid_q;
        end
    end
    assign pid_neg = -pid_clamp;

    // Magnitude with floor applied
    assign duty_mag = pid_clamp[PID_W-1] ? pid_neg[DUTY_BITS-1:0] : pid_clamp[DUTY_BITS-1:0];
    assign duty_out = (duty_mag < i_duty_floor) ? i_duty_floor : duty_mag;

    // Bridge direction and next loop state
    always_comb begin
        if (in_band) begin
            o_fwd_duty        = DUTY_BITS'(1);
            o_rev_duty        = DUTY_BITS'(1);
            o_settled         = 1'b1;
            o_error_sum_next  = '0;
            o_last_error_next = '0;
        end else begin
            o_settled         = 1'b0;
            o_error_sum_next  = sum_new;
            o_last_error_next = err;
            if (pid_clamp == PID_W'(0)) begin
                o_fwd_duty = DUTY_BITS'(1);
                o_rev_duty = DUTY_BITS'(1);
            end else if (pid_clamp[PID_W-1]) begin
                o_fwd_duty = '0;
                o_rev_duty = duty_out;
            end else begin
                o_fwd_duty = duty_out;
                o_rev_duty = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/pid_position_motor_drive.sv =====
// Position PID motor drive, top level: input register, control registers,
// loop state, PID core and the result register.
// Depends on pidm_pkg and pidm_core.
//
// Use:
//  Input channel (i_in_valid / o_in_ready) takes one transaction per cycle
//  unless a tick waits on a stalled output. i_kind = set stores i_value as the
//  new target and clears the error sum and the last error; it produces no
//  result. i_kind = tick carries the encoder count and produces one result
//  transaction on the output channel (o_out_valid / i_out_ready): forward
//  duty, reverse duty and settled. Control registers are written through
//  i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only while
//  the block is idle, which the block does not enforce; writes take effect at
//  once. A tick passes the input register, then the result register, and waits
//  there while the result is stalled. The three gain multiplies, the sum and
//  the clamps sit in the single pass between the two registers, and the loop
//  state is updated in that same pass so back-to-back ticks see each other.
//  Reset (synchronous, active low) clears the target, sum, last error, the
//  gains, deadband, limit and floor, sets the ceiling to its full value,
//  and empties both registers. When the receiver stalls, the result holds;
//  the input register still drains set items and one more tick waits in it.
`default_nettype none

module pid_position_motor_drive
    import pidm_pkg::*;
#(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int DUTY_BITS      = DUTY_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // control register writes
    input  wire logic                         i_cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_kind,
    input  wire logic signed [COUNT_BITS-1:0] i_value,
    // output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic             [DUTY_BITS-1:0]  o_fwd_duty,
    output logic             [DUTY_BITS-1:0]  o_rev_duty,
    output logic                              o_settled
);

    t_cfg                            r_cfg;
    logic        [DUTY_BITS-1:0]     r_duty_floor;
    logic        [DUTY_BITS-1:0]     r_duty_ceiling;

    logic                            r_in_valid;
    logic                            r_in_kind;
    logic signed [COUNT_BITS-1:0]    r_in_value;

    logic signed [COUNT_BITS-1:0]    r_target;
    logic signed [SUM_W-1:0]         r_error_sum;
    logic signed [COUNT_BITS:0]      r_last_error;

    logic                            r_out_valid;
    logic        [DUTY_BITS-1:0]     r_fwd_duty;
    logic        [DUTY_BITS-1:0]     r_rev_duty;
    logic                            r_settled;

    logic signed [SUM_W-1:0]         n_error_sum;
    logic signed [COUNT_BITS:0]      n_last_error;
    logic        [DUTY_BITS-1:0]     n_fwd_duty;
    logic        [DUTY_BITS-1:0]     n_rev_duty;
    logic                            n_settled;

    logic out_free;
    logic fire;
    logic fire_tick;

    // Control register decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg          <= '0;
            r_duty_floor   <= '0;
            r_duty_ceiling <= DUTY_BITS'(DUTY_CEIL_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GAIN_P:     r_cfg.gain_p         <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I_DT:  r_cfg.gain_i_dt      <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D_DT:  r_cfg.gain_d_over_dt <= i_cfg_data[GAIN_W-1:0];
                REG_DEAD_BAND:  r_cfg.dead_band      <= i_cfg_data[BAND_W-1:0];
                REG_SUM_LIMIT:  r_cfg.sum_limit      <= i_cfg_data[LIMIT_W-1:0];
                REG_DUTY_FLOOR: r_duty_floor         <= i_cfg_data[DUTY_BITS-1:0];
                REG_DUTY_CEIL:  r_duty_ceiling       <= i_cfg_data[DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: set items always drain, ticks need room in the result register
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && ((r_in_kind == KIND_SET) || out_free);
    assign fire_tick  = fire && (r_in_kind == KIND_TICK);
    assign o_in_ready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_kind  <= i_kind;
            r_in_value <= i_value;
        end
    end

    // PID arithmetic
    pidm_core #(
        .COUNT_BITS     (COUNT_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DUTY_BITS      (DUTY_BITS)
    ) u_core (
        .i_cfg             (r_cfg),
        .i_duty_floor      (r_duty_floor),
        .i_duty_ceiling    (r_duty_ceiling),
        .i_target          (r_target),
        .i_error_sum       (r_error_sum),
        .i_last_error      (r_last_error),
        .i_value           (r_in_value),
        .o_error_sum_next  (n_error_sum),
        .o_last_error_next (n_last_error),
        .o_fwd_duty        (n_fwd_duty),
        .o_rev_duty        (n_rev_duty),
        .o_settled         (n_settled)
    );

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (fire) begin
            if (r_in_kind == KIND_SET) begin
                r_target     <= r_in_value;
                r_error_sum  <= '0;
                r_last_error <= '0;
            end else begin
                r_error_sum  <= n_error_sum;
                r_last_error <= n_last_error;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_tick) begin
            r_fwd_duty <= n_fwd_duty;
            r_rev_duty <= n_rev_duty;
            r_settled  <= n_settled;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fwd_duty  = r_fwd_duty;
    assign o_rev_duty  = r_rev_duty;
    assign o_settled   = r_settled;

endmodule

`default_nettype wire

// ===== sv/pidm_checker.sv =====
// Port-level checks for the position PID motor drive, bound to the top level.
// Depends on pidm_pkg and pid_position_motor_drive.
`default_nettype none

module pidm_checker
    import pidm_pkg::*;
#(
    parameter int DUTY_BITS  = DUTY_BITS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic        [DUTY_BITS-1:0]  o_fwd_duty,
    input wire logic        [DUTY_BITS-1:0]  o_rev_duty,
    input wire logic                         o_settled
);

    // No result survives a reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_fwd_duty) && $stable(o_rev_duty)
             && $stable(o_settled)))
        else $error("stalled result changed");

    // Inside the deadband the bridge is held with both duties at one
    a_settled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_settled) |->
            (o_fwd_duty == DUTY_BITS'(1) && o_rev_duty == DUTY_BITS'(1)))
        else $error("settled result without hold duties");

    // Both bridge inputs are driven only in the hold pattern
    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fwd_duty != '0 && o_rev_duty != '0) |->
            (o_fwd_duty == DUTY_BITS'(1) && o_rev_duty == DUTY_BITS'(1)))
        else $error("forward and reverse both driven");

    // With the result register empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind pid_position_motor_drive pidm_checker #(
    .DUTY_BITS  (DUTY_BITS)
) u_pidm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_fwd_duty  (o_fwd_duty),
    .o_rev_duty  (o_rev_duty),
    .o_settled   (o_settled)
);

`default_nettype wire
